@@ src/ssr_pkg.sv @@
// Shared types and constants for the streaming search-and-replace block.
// No dependencies; every other file in src uses this package.
package ssr_pkg;

    localparam int PATTERN_MAX_DEF = 8;

    // Register indexes (paddr[4:3])
    localparam logic [1:0] REG_PATTERN_BYTES      = 2'd0;
    localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd1;
    localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } ssr_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       out_last;
    } ssr_out_t;

    typedef struct packed {
        logic [63:0] pattern_bytes;
        logic [3:0]  pattern_length;
        logic [63:0] replacement_bytes;
        logic [3:0]  replacement_length;
        logic        pattern_write;   // pulse: pattern changed, drop partial match
    } ssr_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REPL,
        ST_FLUSH,
        ST_END
    } ssr_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;        // accept input byte into the prefix buffer
        logic pass;        // empty pattern: input byte straight to output
        logic pop_emit;    // emit head of buffer, drop it
        logic rep_emit;    // emit next replacement byte
        logic end_emit;    // emit bare end marker
        logic clear_count; // full match found
    } ssr_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic slot_free;
        logic plen_zero;
        logic rlen_zero;
        logic is_prefix;
        logic full_match;
        logic count_zero;
        logic count_one;
        logic rep_done;
        logic last;
    } ssr_stat_t;

endpackage

@@ src/ssr_regs.sv @@
// APB-style configuration registers for the search-and-replace block.
// Depends on ssr_pkg.
module ssr_regs (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [4:0]      paddr,
    input  logic [63:0]     pwdata,
    output logic [63:0]     prdata,
    output logic            pready,
    output ssr_pkg::ssr_cfg_t cfg
);

    logic [63:0] pat_bytes_reg;
    logic [3:0]  pat_len_reg;
    logic [63:0] rep_bytes_reg;
    logic [3:0]  rep_len_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= '0;
            rep_bytes_reg <= '0;
            rep_len_reg   <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                ssr_pkg::REG_PATTERN_BYTES:      pat_bytes_reg <= pwdata;
                ssr_pkg::REG_PATTERN_LENGTH:     pat_len_reg   <= pwdata[3:0];
                ssr_pkg::REG_REPLACEMENT_BYTES:  rep_bytes_reg <= pwdata;
                ssr_pkg::REG_REPLACEMENT_LENGTH: rep_len_reg   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ssr_pkg::REG_PATTERN_BYTES:      prdata = pat_bytes_reg;
            ssr_pkg::REG_PATTERN_LENGTH:     prdata = {60'd0, pat_len_reg};
            ssr_pkg::REG_REPLACEMENT_BYTES:  prdata = rep_bytes_reg;
            ssr_pkg::REG_REPLACEMENT_LENGTH: prdata = {60'd0, rep_len_reg};
            default:                         prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.pattern_bytes      = pat_bytes_reg;
        cfg.pattern_length     = pat_len_reg;
        cfg.replacement_bytes  = rep_bytes_reg;
        cfg.replacement_length = rep_len_reg;
        cfg.pattern_write      = wr_en && (reg_idx == ssr_pkg::REG_PATTERN_BYTES
                                       || reg_idx == ssr_pkg::REG_PATTERN_LENGTH);
    end

endmodule

@@ src/ssr_dp.sv @@
// Datapath: prefix buffer, prefix compare, replacement index and output register.
// Depends on ssr_pkg; driven by ssr_ctrl commands.
module ssr_dp #(
    parameter int PATTERN_MAX = ssr_pkg::PATTERN_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ssr_pkg::ssr_cfg_t  cfg,
    input  ssr_pkg::ssr_in_t   in_data,
    input  ssr_pkg::ssr_cmd_t  cmd,
    output ssr_pkg::ssr_stat_t stat,
    output logic               out_valid,
    input  logic               out_stall,
    output ssr_pkg::ssr_out_t  out_data
);

    localparam int CW = $clog2(PATTERN_MAX + 1);
    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [7:0]        hold_reg  [PATTERN_MAX];
    logic [7:0]        hold_next [PATTERN_MAX];
    logic [CW-1:0]     count_reg, count_next;
    logic [IW-1:0]     rep_idx_reg, rep_idx_next;
    logic              last_reg;
    logic              out_valid_reg, out_valid_next;
    ssr_pkg::ssr_out_t out_data_reg, out_data_next;

    logic [CW-1:0]     plen, rlen;
    logic [CW-1:0]     wr_idx;
    logic              mismatch;
    logic [7:0]        rep_byte;

    // Lengths above the buffer depth saturate
    assign plen = (cfg.pattern_length > 4'(PATTERN_MAX)) ? CW'(PATTERN_MAX)
                                                         : CW'(cfg.pattern_length);
    assign rlen = (cfg.replacement_length > 4'(PATTERN_MAX)) ? CW'(PATTERN_MAX)
                                                             : CW'(cfg.replacement_length);

    assign wr_idx   = (count_reg >= plen) ? '0 : count_reg;
    assign rep_byte = cfg.replacement_bytes[8*rep_idx_reg +: 8];

    always_comb
    begin
        mismatch = (count_reg > plen);
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if ((CW'(i) < count_reg) && (hold_reg[i] != cfg.pattern_bytes[8*i +: 8]))
                mismatch = 1'b1;
        end
    end

    always_comb
    begin
        stat.slot_free  = !out_valid_reg || !out_stall;
        stat.plen_zero  = (plen == '0);
        stat.rlen_zero  = (rlen == '0);
        stat.is_prefix  = !mismatch;
        stat.full_match = !mismatch && (count_reg == plen);
        stat.count_zero = (count_reg == '0);
        stat.count_one  = (count_reg == CW'(1));
        stat.rep_done   = ((CW'(rep_idx_reg) + CW'(1)) == rlen);
        stat.last       = last_reg;
    end

    always_comb
    begin
        hold_next      = hold_reg;
        count_next     = count_reg;
        rep_idx_next   = rep_idx_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cmd.load)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                if (wr_idx == CW'(i))
                    hold_next[i] = in_data.in_byte;
            end
            count_next   = wr_idx + CW'(1);
            rep_idx_next = '0;
        end

        if (cmd.pass)
        begin
            count_next     = '0;
            out_data_next  = '{out_byte: in_data.in_byte, byte_valid: 1'b1,
                              out_last: in_data.in_last};
            out_valid_next = 1'b1;
        end

        if (cmd.pop_emit)
        begin
            for (int i = 0; i < PATTERN_MAX - 1; i++)
                hold_next[i] = hold_reg[i+1];
            count_next     = count_reg - CW'(1);
            // once the stream ends, every buffered byte is flushed in order
            out_data_next  = '{out_byte: hold_reg[0], byte_valid: 1'b1,
                              out_last: last_reg && stat.count_one};
            out_valid_next = 1'b1;
        end

        if (cmd.rep_emit)
        begin
            rep_idx_next   = rep_idx_reg + IW'(1);
            out_data_next  = '{out_byte: rep_byte, byte_valid: 1'b1,
                              out_last: last_reg && stat.rep_done};
            out_valid_next = 1'b1;
        end

        if (cmd.end_emit)
        begin
            out_data_next  = '{out_byte: 8'd0, byte_valid: 1'b0, out_last: 1'b1};
            out_valid_next = 1'b1;
        end

        if (cmd.clear_count || cfg.pattern_write)
            count_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        rep_idx_reg  <= rep_idx_next;
        out_data_reg <= out_data_next;
        if (cmd.load)
            last_reg <= in_data.in_last;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ src/ssr_ctrl.sv @@
// Controller FSM: sequences pass-through, accept, prefix check, release, replacement, flush and end marker.
// Depends on ssr_pkg; drives ssr_dp through command/status structs.
module ssr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ssr_pkg::ssr_stat_t stat,
    output ssr_pkg::ssr_cmd_t  cmd
);

    ssr_pkg::ssr_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ssr_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;

        unique case (state_reg)
            ssr_pkg::ST_IDLE:
            begin
                // pass-through needs the output slot in the same cycle
                in_stall = stat.plen_zero && !stat.slot_free;
                if (in_valid && !in_stall)
                begin
                    if (stat.plen_zero)
                        cmd.pass = 1'b1;
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = ssr_pkg::ST_CHECK;
                    end
                end
            end

            ssr_pkg::ST_CHECK:
            begin
                if (stat.count_zero)
                    state_next = ssr_pkg::ST_IDLE;
                else if (stat.full_match)
                begin
                    cmd.clear_count = 1'b1;
                    if (!stat.rlen_zero)
                        state_next = ssr_pkg::ST_REPL;
                    else if (stat.last)
                        state_next = ssr_pkg::ST_END;
                    else
                        state_next = ssr_pkg::ST_IDLE;
                end
                else if (stat.is_prefix)
                    state_next = stat.last ? ssr_pkg::ST_FLUSH : ssr_pkg::ST_IDLE;
                else if (stat.slot_free)
                    cmd.pop_emit = 1'b1;   // release head, recheck the rest
            end

            ssr_pkg::ST_REPL:
            begin
                if (stat.slot_free)
                begin
                    cmd.rep_emit = 1'b1;
                    if (stat.rep_done)
                        state_next = ssr_pkg::ST_IDLE;
                end
            end

            ssr_pkg::ST_FLUSH:
            begin
                if (stat.slot_free)
                begin
                    cmd.pop_emit = 1'b1;
                    if (stat.count_one)
                        state_next = ssr_pkg::ST_IDLE;
                end
            end

            ssr_pkg::ST_END:
            begin
                if (stat.slot_free)
                begin
                    cmd.end_emit = 1'b1;
                    state_next   = ssr_pkg::ST_IDLE;
                end
            end

            default: state_next = ssr_pkg::ST_IDLE;
        endcase
    end

endmodule

@@ src/stream_search_replace_top.sv @@
// Empty pattern: a transfer in goes straight into the output register. Otherwise a
// byte is accepted into the prefix buffer, then compared, releasing bytes from the head
// while rechecking until a closing compare, then replacement or flushed bytes follow.
// Each input byte gives up to PATTERN_MAX output transfers through the single byte-wide
// output register; input is taken only in the idle state, and output stall holds it up.
// Reset: configuration registers zero, prefix buffer empty; no clearing pass.
module stream_search_replace_top #(
    parameter int PATTERN_MAX = ssr_pkg::PATTERN_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  ssr_pkg::ssr_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output ssr_pkg::ssr_out_t out_data
);

    ssr_pkg::ssr_cfg_t  cfg;
    ssr_pkg::ssr_cmd_t  cmd;
    ssr_pkg::ssr_stat_t stat;

    ssr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ssr_dp #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

@@ test/tb_stream_search_replace_top.sv @@
// Testbench for stream_search_replace_top: random byte streams against a predictor of
// the search-and-replace behavior, APB register setup with readback. Depends on ssr_pkg.
`timescale 1ns / 100ps

module tb_stream_search_replace_top;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE       = 20;
    localparam int RANDOM_ITEMS = 380;

    // Expected output stream of the block, built byte by byte from accepted transfers.
    class replace_scoreboard;
        logic [63:0]       pat_word;
        logic [3:0]        pat_len_reg;
        logic [63:0]       rep_word;
        logic [3:0]        rep_len_reg;
        logic [7:0]        held [ssr_pkg::PATTERN_MAX_DEF];
        int                held_n;
        int                step_n;
        ssr_pkg::ssr_out_t pending_out [$];
        int                failures;
        int                match_count;
        int                bare_ends;
        int                out_count;

        function new();
            pat_word    = '0;
            pat_len_reg = '0;
            rep_word    = '0;
            rep_len_reg = '0;
            held_n      = 0;
            failures    = 0;
            match_count = 0;
            bare_ends   = 0;
            out_count   = 0;
        endfunction

        function void flag_failure(string msg);
            failures++;
            if (failures <= 10)
                $display("ERROR: %s", msg);
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] val);
            case (idx)
                ssr_pkg::REG_PATTERN_BYTES:
                begin
                    pat_word = val;
                    held_n   = 0;
                end
                ssr_pkg::REG_PATTERN_LENGTH:
                begin
                    pat_len_reg = val[3:0];
                    held_n      = 0;
                end
                ssr_pkg::REG_REPLACEMENT_BYTES:  rep_word    = val;
                ssr_pkg::REG_REPLACEMENT_LENGTH: rep_len_reg = val[3:0];
            endcase
        endfunction

        function int sat_len(logic [3:0] v);
            return (v > ssr_pkg::PATTERN_MAX_DEF) ? ssr_pkg::PATTERN_MAX_DEF : int'(v);
        endfunction

        function bit held_is_prefix(int plen);
            if (held_n > plen)
                return 1'b0;
            for (int i = 0; i < held_n; i++)
                if (held[i] != pat_word[8*i +: 8])
                    return 1'b0;
            return 1'b1;
        endfunction

        function void emit(logic [7:0] b, logic v);
            ssr_pkg::ssr_out_t o;
            if (step_n >= ssr_pkg::PATTERN_MAX_DEF)
                return;
            o.out_byte   = b;
            o.byte_valid = v;
            o.out_last   = 1'b0;
            pending_out.push_back(o);
            step_n++;
        endfunction

        function void note_byte(ssr_pkg::ssr_in_t it);
            int plen;
            int rlen;
            plen   = sat_len(pat_len_reg);
            rlen   = sat_len(rep_len_reg);
            step_n = 0;
            if (plen == 0)
            begin
                held_n = 0;
                emit(it.in_byte, 1'b1);
            end
            else
            begin
                if (held_n >= plen)
                    held_n = 0;
                held[held_n] = it.in_byte;
                held_n++;
                // release from the front until the rest is a prefix again
                while (held_n > 0)
                begin
                    if (held_is_prefix(plen))
                    begin
                        if (held_n == plen)
                        begin
                            for (int i = 0; i < rlen; i++)
                                emit(rep_word[8*i +: 8], 1'b1);
                            held_n = 0;
                            match_count++;
                        end
                        break;
                    end
                    emit(held[0], 1'b1);
                    for (int i = 1; i < held_n; i++)
                        held[i-1] = held[i];
                    held_n--;
                end
            end
            if (it.in_last)
            begin
                for (int i = 0; i < held_n; i++)
                    emit(held[i], 1'b1);
                held_n = 0;
                if (step_n == 0)
                begin
                    emit(8'h00, 1'b0);
                    bare_ends++;
                end
                pending_out[pending_out.size()-1].out_last = 1'b1;
            end
        endfunction

        function void check_output(ssr_pkg::ssr_out_t got);
            ssr_pkg::ssr_out_t want;
            out_count++;
            if (pending_out.size() == 0)
            begin
                flag_failure($sformatf("unexpected output byte=%h valid=%b last=%b",
                    got.out_byte, got.byte_valid, got.out_last));
                return;
            end
            want = pending_out.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.out_last !== want.out_last)
                flag_failure($sformatf(
                    "output %0d: expected byte=%h valid=%b last=%b, got byte=%h valid=%b last=%b",
                    out_count, want.out_byte, want.byte_valid, want.out_last,
                    got.out_byte, got.byte_valid, got.out_last));
        endfunction
    endclass

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [4:0]        paddr    = '0;
    logic [63:0]       pwdata   = '0;
    logic [63:0]       prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_stall;
    ssr_pkg::ssr_in_t  in_data  = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    ssr_pkg::ssr_out_t out_data;

    replace_scoreboard sb;
    int          cycles      = 0;
    int          byte_count  = 0;
    int          stream_count = 0;
    int          setting_count = 0;
    int          hold_req    = 0;
    bit          quiet       = 1'b0;
    logic [7:0]  alpha [3];

    stream_search_replace_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("stream_search_replace_top verification failed");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none in quiet phases
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // output side: random stall, plus a long hold-off on request
    initial
    begin : out_side
        int stall_left;
        int g;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_output(out_data);
            if (hold_req > 0)
            begin
                stall_left = hold_req;
                hold_req   = 0;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                g = pick_gap();
                out_stall <= (g > 0);
                stall_left = (g > 0) ? g - 1 : 0;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic l);
        int g;
        in_data  <= '{in_byte: b, in_last: l};
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_byte('{in_byte: b, in_last: l});
        byte_count++;
        if (l)
            stream_count++;
        g = pick_gap();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // wait for every expected byte, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [63:0] val);
        logic [63:0] want;
        want = (idx == ssr_pkg::REG_PATTERN_LENGTH || idx == ssr_pkg::REG_REPLACEMENT_LENGTH) ?
               {60'd0, val[3:0]} : val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(idx, val);
        // read back straight away: psel stays high, new setup phase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
            sb.flag_failure($sformatf("register %0d readback: expected %h, got %h",
                idx, want, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [63:0] pat, input logic [3:0] plen,
                             input logic [63:0] rep, input logic [3:0] rlen);
        write_cfg(ssr_pkg::REG_PATTERN_BYTES, pat);
        write_cfg(ssr_pkg::REG_PATTERN_LENGTH, {60'd0, plen});
        write_cfg(ssr_pkg::REG_REPLACEMENT_BYTES, rep);
        write_cfg(ssr_pkg::REG_REPLACEMENT_LENGTH, {60'd0, rlen});
        setting_count++;
    endtask

    // stream mixing whole pattern copies, broken prefixes and noise
    task automatic send_stream(input int len, input bit close);
        int   k;
        int   plen;
        int   r;
        int   cnt;
        logic [7:0] chunk [ssr_pkg::PATTERN_MAX_DEF];
        k    = 0;
        plen = sb.sat_len(sb.pat_len_reg);
        while (k < len)
        begin
            r = $urandom_range(0, 99);
            if (plen > 0 && r < 35)
                cnt = plen;
            else if (plen > 1 && r < 60)
                cnt = $urandom_range(1, plen - 1);
            else
                cnt = 0;
            for (int i = 0; i < cnt; i++)
                chunk[i] = sb.pat_word[8*i +: 8];
            if (cnt == 0)
            begin
                cnt = 1;
                chunk[0] = (r < 90) ? alpha[$urandom_range(0, 2)] : 8'($urandom_range(0, 255));
            end
            for (int i = 0; i < cnt && k < len; i++)
            begin
                send_byte(chunk[i], close && (k == len - 1));
                k++;
            end
        end
    endtask

    initial
    begin : stimulus
        int start_count;
        int target;
        int sent;
        int len;
        int r;
        int phase;
        logic [63:0] pat;
        logic [3:0]  plen;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // after reset the pattern is empty: bytes pass straight through
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();

        // overlapping candidates, partial match breaks and release from the front
        configure(64'h0000_0000_0041_4241, 4'd3, 64'h0000_0000_0000_7978, 4'd2);
        send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b1);
        drain();

        // empty replacement: a match on the final byte leaves only a bare end marker
        write_cfg(ssr_pkg::REG_REPLACEMENT_LENGTH, 64'd0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h41, 1'b1);
        send_byte(8'h41, 1'b1);
        drain();

        // lengths above the maximum saturate to eight
        configure(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'h0123_4567_89AB_CDEF, 4'd12);
        for (int i = 0; i < 8; i++)
            send_byte(8'hFF, i == 7);
        drain();

        // pattern change mid-stream drops the held partial match
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        drain();
        write_cfg(ssr_pkg::REG_PATTERN_LENGTH, 64'd3);
        send_byte(8'hFF, 1'b1);
        drain();

        start_count = byte_count;
        phase = 0;
        while (byte_count - start_count < RANDOM_ITEMS)
        begin
            for (int j = 0; j < 3; j++)
                alpha[j] = 8'($urandom_range(0, 255));
            r    = $urandom_range(0, 9);
            plen = (r == 0) ? 4'd0 : (r == 9) ? 4'($urandom_range(8, 15)) : 4'(r);
            pat  = {$urandom, $urandom};
            for (int i = 0; i < 8; i++)
                if ($urandom_range(0, 3) != 0)
                    pat[8*i +: 8] = alpha[$urandom_range(0, 2)];
            configure(pat, plen, {$urandom, $urandom}, 4'($urandom_range(0, 15)));
            quiet  = ($urandom_range(0, 3) == 0) && phase != 1;
            target = $urandom_range(30, 50);
            sent   = 0;
            // long output hold-off while input keeps coming, so the block backs up
            if (phase == 1)
                hold_req = 250;
            while (sent < target)
            begin
                len = $urandom_range(1, 20);
                if (sent + len > target)
                    len = target - sent;
                sent += len;
                // now and then leave the stream open across the next setting
                send_stream(len, sent < target || $urandom_range(0, 2) != 0);
            end
            drain();
            phase++;
        end

        quiet = 1'b1;
        drain();
        if (sb.pending_out.size() != 0)
            sb.flag_failure($sformatf("%0d expected bytes never arrived",
                sb.pending_out.size()));
        $display("sent %0d bytes in %0d closed streams over %0d settings",
            byte_count, stream_count, setting_count);
        $display("checked %0d output transfers: %0d replacements, %0d bare end markers",
            sb.out_count, sb.match_count, sb.bare_ends);
        if (sb.failures == 0)
            $display("stream_search_replace_top verification clean");
        else
            $display("stream_search_replace_top verification failed");
        $finish;
    end

endmodule
